// File: design/radio_pairing_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Radio pairing controller assertion macros
// Shared assertion forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIO_PAIRING_CONTROLLER_UNIT_MACROS_SVH
`define RADIO_PAIRING_CONTROLLER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define RPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger in one cycle that must be followed by a condition in the next.
`define RPC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: design/rpc_pkg.sv
// ----------------------------------------------------------------------------
// Radio pairing controller package
// Constants, codes, the channel map and the item types shared by the block.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int DIAL_W       = 4;
  localparam int RADIO_W      = 5;
  localparam int COUNT_W      = 8;
  localparam int WINDOW_W     = 18;
  localparam int CFG_W        = 18;
  localparam int CFG_IDX_W    = 1;

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'hFF;
  localparam logic [COUNT_W-1:0]  THRESH_RST   = 8'd5;
  localparam logic [WINDOW_W-1:0] WINDOW_RST   = 18'd200000;

  // Dial channel to radio channel map.
  localparam logic [RADIO_W-1:0] CHAN_MAP [16] = '{
    5'd31, 5'd29, 5'd0,  5'd2,  5'd6,  5'd4,  5'd8,  5'd10,
    5'd14, 5'd12, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25, 5'd27
  };

  typedef enum logic [2:0] {
    ACT_START    = 3'd0,
    ACT_STOP     = 3'd1,
    ACT_SET_CHAN = 3'd2,
    ACT_SYNC     = 3'd3,
    ACT_PACKET   = 3'd4,
    ACT_RX_FAIL  = 3'd5,
    ACT_CAL_FAIL = 3'd6,
    ACT_TICK     = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_STARTED   = 3'd1,
    EV_SUCCESS   = 3'd2,
    EV_CANCELLED = 3'd3,
    EV_PKT_ACC   = 3'd4,
    EV_ERROR     = 3'd5,
    EV_REJECTED  = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SCAN   = 2'd1,
    MODE_QUAL   = 2'd2,
    MODE_ACTIVE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PERR_NONE      = 2'd0,
    PERR_NO_PACKET = 2'd1,
    PERR_CAL       = 2'd2
  } perr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_WINDOW    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    action_t            action;
    logic [7:0]         dial_request;
    logic [RADIO_W-1:0] detected_channel;
    logic               packet_qualifies;
  } in_item_t;

  typedef struct packed {
    event_t             event_res;
    logic [DIAL_W-1:0]  reported_channel;
    logic               tune_valid;
    logic [RADIO_W-1:0] tune_channel;
    logic               hopping_on;
    logic               error_kind;
    mode_t              mode;
  } res_item_t;

endpackage

// File: design/rpc_if.sv
// ----------------------------------------------------------------------------
// Radio pairing controller channel interfaces
// Valid/ready channels for event items in and result items out.
// ----------------------------------------------------------------------------
interface rpc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] dial_request;
  logic [4:0] detected_channel;
  logic       packet_qualifies;

  modport source (output valid, action, dial_request, detected_channel,
                  packet_qualifies, input ready);
  modport sink   (input valid, action, dial_request, detected_channel,
                  packet_qualifies, output ready);
endinterface

interface rpc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [3:0] reported_channel;
  logic       tune_valid;
  logic [4:0] tune_channel;
  logic       hopping_on;
  logic       error_kind;
  logic [1:0] mode;

  modport source (output valid, event_res, reported_channel, tune_valid,
                  tune_channel, hopping_on, error_kind, mode, input ready);
  modport sink   (input valid, event_res, reported_channel, tune_valid,
                  tune_channel, hopping_on, error_kind, mode, output ready);
endinterface

// File: design/radio_pairing_controller_unit.sv
// ----------------------------------------------------------------------------
// Radio pairing controller unit
// Receiver pairing and channel controller, one result item per event item.
//
// Event items arrive on in_ch (valid/ready): start or stop pairing, set
// channel, sync detected, packet received, rx or calibration failure, tick.
// Every accepted item gives exactly one result item on out_ch, carrying the
// event report, a retune request, the hopping flag and the new mode.
// An accepted item is held in an input register; when it advances, the
// engine updates the pairing state and the result is captured in the output
// register, from which it is offered on out_ch until it is taken.
// Both stages advance together, so one item per cycle is sustained while
// the receiver keeps out_ch.ready high.
// When the receiver stalls, the output register holds its result and the
// input register fills behind it; in_ch.ready then drops until out_ch is
// taken. The user must write the threshold and window registers through the
// cfg_ port only while no item is in flight; the block does not enforce it.
// Reset (rst_n low at a clock edge) empties both stages, puts the block in
// idle and restores a threshold of five and a window of 200000 ticks.
// ----------------------------------------------------------------------------
`include "radio_pairing_controller_unit_macros.svh"

module radio_pairing_controller_unit
  import rpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  rpc_in_if.sink               in_ch,
  rpc_out_if.source            out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [COUNT_W-1:0]  thresh_r;
  logic [WINDOW_W-1:0] window_r;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  res_item_t out_res_r;
  res_item_t res;

  logic in_fire;
  logic s1_adv;

  // Configuration registers; the index is fully decoded by the enum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      window_r <= WINDOW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: thresh_r <= cfg_wdata[COUNT_W-1:0];
        CFG_WINDOW:    window_r <= cfg_wdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the output register is free or
  // is being emptied in this cycle.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action           <= action_t'(in_ch.action);
      s1_item_r.dial_request     <= in_ch.dial_request;
      s1_item_r.detected_channel <= in_ch.detected_channel;
      s1_item_r.packet_qualifies <= in_ch.packet_qualifies;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  rpc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_adv),
    .item      (s1_item_r),
    .threshold (thresh_r),
    .window    (window_r),
    .res       (res)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.event_res        = out_res_r.event_res;
  assign out_ch.reported_channel = out_res_r.reported_channel;
  assign out_ch.tune_valid       = out_res_r.tune_valid;
  assign out_ch.tune_channel     = out_res_r.tune_channel;
  assign out_ch.hopping_on       = out_res_r.hopping_on;
  assign out_ch.error_kind       = out_res_r.error_kind;
  assign out_ch.mode             = out_res_r.mode;

  `RPC_ASSERT_NEXT(a_accept_fills, in_fire, s1_valid_r, "accepted item not held in input stage")
  `RPC_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_r, "advanced item not held in output stage")
  `RPC_ASSERT_NEXT(a_cfg_thresh, cfg_wr_en && cfg_index == CFG_THRESHOLD, thresh_r == $past(cfg_wdata[COUNT_W-1:0]), "threshold write lost")

endmodule

// File: design/rpc_engine.sv
// ----------------------------------------------------------------------------
// Radio pairing controller engine
// Holds the pairing state and works out one result item per step.
// ----------------------------------------------------------------------------
`include "radio_pairing_controller_unit_macros.svh"

module rpc_engine
  import rpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  in_item_t            item,
  input  logic [COUNT_W-1:0]  threshold,
  input  logic [WINDOW_W-1:0] window,
  output res_item_t           res
);

  mode_t               mode_r,   mode_nxt;
  logic [DIAL_W-1:0]   dial_r,   dial_nxt;
  logic [RADIO_W-1:0]  cand_r,   cand_nxt;
  logic [COUNT_W-1:0]  count_r,  count_nxt;
  logic [WINDOW_W-1:0] window_r, window_nxt;
  perr_t               perr_r,   perr_nxt;

  logic [COUNT_W-1:0]  count_inc;
  logic                hit;
  logic [DIAL_W-1:0]   hit_idx;

  assign count_inc = (item.packet_qualifies && count_r != COUNT_MAX) ?
                     count_r + COUNT_W'(1) : count_r;

  // Reverse lookup of the candidate in the channel map, lowest entry first.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (CHAN_MAP[i] == cand_r) begin
        hit     = 1'b1;
        hit_idx = DIAL_W'(i);
      end
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    dial_nxt   = dial_r;
    cand_nxt   = cand_r;
    count_nxt  = count_r;
    window_nxt = window_r;
    perr_nxt   = perr_r;
    res        = '0;
    res.event_res = EV_NONE;
    case (item.action)
      ACT_START: begin
        mode_nxt         = MODE_SCAN;
        res.tune_valid   = 1'b1;
        res.tune_channel = CHAN_MAP[0];
        res.event_res    = EV_STARTED;
      end
      ACT_STOP: begin
        mode_nxt             = MODE_ACTIVE;
        res.tune_valid       = 1'b1;
        res.tune_channel     = CHAN_MAP[dial_r];
        res.event_res        = EV_CANCELLED;
        res.reported_channel = dial_r;
      end
      ACT_SET_CHAN: begin
        if (item.dial_request >= 8'(NUM_CHANNELS)) begin
          res.event_res = EV_REJECTED;
        end else begin
          dial_nxt         = item.dial_request[DIAL_W-1:0];
          mode_nxt         = MODE_ACTIVE;
          res.tune_valid   = 1'b1;
          res.tune_channel = CHAN_MAP[item.dial_request[DIAL_W-1:0]];
        end
      end
      ACT_SYNC: begin
        if (mode_r == MODE_SCAN) begin
          cand_nxt         = item.detected_channel;
          count_nxt        = '0;
          window_nxt       = window;
          mode_nxt         = MODE_QUAL;
          res.tune_valid   = 1'b1;
          res.tune_channel = item.detected_channel;
        end
      end
      ACT_PACKET: begin
        if (mode_r == MODE_QUAL) begin
          count_nxt = count_inc;
          if (count_inc >= threshold && hit) begin
            dial_nxt             = hit_idx;
            mode_nxt             = MODE_ACTIVE;
            res.tune_valid       = 1'b1;
            res.tune_channel     = CHAN_MAP[hit_idx];
            res.event_res        = EV_SUCCESS;
            res.reported_channel = hit_idx;
          end
        end else if (mode_r == MODE_ACTIVE) begin
          res.event_res = EV_PKT_ACC;
        end
      end
      ACT_RX_FAIL:  perr_nxt = PERR_NO_PACKET;
      ACT_CAL_FAIL: perr_nxt = PERR_CAL;
      ACT_TICK: begin
        if (mode_r == MODE_QUAL) begin
          if (window_r == '0) begin
            mode_nxt         = MODE_SCAN;
            res.tune_valid   = 1'b1;
            res.tune_channel = CHAN_MAP[0];
          end else begin
            window_nxt = window_r - WINDOW_W'(1);
          end
        end else if (mode_r == MODE_ACTIVE && perr_r != PERR_NONE) begin
          res.event_res  = EV_ERROR;
          res.error_kind = (perr_r == PERR_CAL);
          perr_nxt       = PERR_NONE;
        end
      end
      default: ;
    endcase
    res.mode       = mode_nxt;
    res.hopping_on = (mode_nxt == MODE_SCAN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      dial_r   <= '0;
      cand_r   <= '0;
      count_r  <= '0;
      window_r <= '0;
      perr_r   <= PERR_NONE;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      dial_r   <= dial_nxt;
      cand_r   <= cand_nxt;
      count_r  <= count_nxt;
      window_r <= window_nxt;
      perr_r   <= perr_nxt;
    end
  end

  `RPC_ASSERT_ALWAYS(a_dial_in_range, {1'b0, dial_r} < 5'(NUM_CHANNELS), "dial channel out of range")
  `RPC_ASSERT_NEXT(a_start_scans, step_en && item.action == ACT_START, mode_r == MODE_SCAN, "start did not enter scanning")
  `RPC_ASSERT_NEXT(a_error_clears, step_en && res.event_res == EV_ERROR, perr_r == PERR_NONE, "reported error still latched")

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Radio pairing controller testbench
// Drives event items into the pairing controller with bursty valid and a
// stalling result receiver. A scoreboard class keeps its own copy of the
// pairing state and the two registers. It predicts one result item for every
// accepted event item and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module tb
  import rpc_pkg::*;
();

  // If this many cycles pass with no handshake on either channel, the block
  // is taken to be hung.
  localparam int QUIET_LIMIT = 1000;

  // Dial channel to radio channel map, kept independently of the package.
  localparam logic [RADIO_W-1:0] DIAL_TO_RADIO [16] = '{
    5'd31, 5'd29, 5'd0,  5'd2,  5'd6,  5'd4,  5'd8,  5'd10,
    5'd14, 5'd12, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25, 5'd27
  };

  // Tracks the pairing state, works out the result of each accepted event
  // item and holds those results until the block hands them out.
  class pairing_scoreboard;
    res_item_t           awaited[$];
    logic [COUNT_W-1:0]  threshold;
    logic [WINDOW_W-1:0] window;
    mode_t               mode_now;
    logic [DIAL_W-1:0]   dial;
    logic [RADIO_W-1:0]  candidate;
    logic [COUNT_W-1:0]  qual_count;
    logic [WINDOW_W-1:0] ticks_left;
    perr_t               latched_err;
    int unsigned         n_events, n_results, n_fail;
    int unsigned         n_paired, n_expired, n_errors, n_rejected;

    function new();
      threshold   = 8'd5;
      window      = 18'd200000;
      mode_now    = MODE_IDLE;
      dial        = '0;
      candidate   = '0;
      qual_count  = '0;
      ticks_left  = '0;
      latched_err = PERR_NONE;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
      if (idx == CFG_THRESHOLD) begin
        threshold = value[COUNT_W-1:0];
      end else begin
        window = value[WINDOW_W-1:0];
      end
    endfunction

    function res_item_t pairing_step(in_item_t it);
      res_item_t r;
      bit        found;
      int        hit;
      r     = '0;
      found = 1'b0;
      hit   = 0;
      case (it.action)
        ACT_START: begin
          mode_now       = MODE_SCAN;
          r.tune_valid   = 1'b1;
          r.tune_channel = DIAL_TO_RADIO[0];
          r.event_res    = EV_STARTED;
        end
        ACT_STOP: begin
          mode_now           = MODE_ACTIVE;
          r.tune_valid       = 1'b1;
          r.tune_channel     = DIAL_TO_RADIO[dial];
          r.event_res        = EV_CANCELLED;
          r.reported_channel = dial;
        end
        ACT_SET_CHAN: begin
          if (it.dial_request >= NUM_CHANNELS) begin
            r.event_res = EV_REJECTED;
            n_rejected++;
          end else begin
            dial           = it.dial_request[DIAL_W-1:0];
            mode_now       = MODE_ACTIVE;
            r.tune_valid   = 1'b1;
            r.tune_channel = DIAL_TO_RADIO[dial];
          end
        end
        ACT_SYNC: begin
          if (mode_now == MODE_SCAN) begin
            candidate      = it.detected_channel;
            qual_count     = '0;
            ticks_left     = window;
            mode_now       = MODE_QUAL;
            r.tune_valid   = 1'b1;
            r.tune_channel = it.detected_channel;
          end
        end
        ACT_PACKET: begin
          if (mode_now == MODE_QUAL) begin
            if (it.packet_qualifies && qual_count != COUNT_MAX) qual_count++;
            if (qual_count >= threshold) begin
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (!found && DIAL_TO_RADIO[i] == candidate) begin
                  found = 1'b1;
                  hit   = i;
                end
              end
              if (found) begin
                dial               = hit[DIAL_W-1:0];
                mode_now           = MODE_ACTIVE;
                r.tune_valid       = 1'b1;
                r.tune_channel     = DIAL_TO_RADIO[hit];
                r.event_res        = EV_SUCCESS;
                r.reported_channel = dial;
                n_paired++;
              end
            end
          end else if (mode_now == MODE_ACTIVE) begin
            r.event_res = EV_PKT_ACC;
          end
        end
        ACT_RX_FAIL:  latched_err = PERR_NO_PACKET;
        ACT_CAL_FAIL: latched_err = PERR_CAL;
        default: begin
          if (mode_now == MODE_QUAL) begin
            if (ticks_left == 0) begin
              mode_now       = MODE_SCAN;
              r.tune_valid   = 1'b1;
              r.tune_channel = DIAL_TO_RADIO[0];
              n_expired++;
            end else begin
              ticks_left--;
            end
          end else if (mode_now == MODE_ACTIVE && latched_err != PERR_NONE) begin
            r.event_res  = EV_ERROR;
            r.error_kind = (latched_err == PERR_CAL);
            latched_err  = PERR_NONE;
            n_errors++;
          end
        end
      endcase
      r.hopping_on = (mode_now == MODE_SCAN);
      r.mode       = mode_now;
      return r;
    endfunction

    function void note_event(in_item_t it);
      n_events++;
      awaited.push_back(pairing_step(it));
    endfunction

    // Only the first few mismatches are printed; all of them are counted.
    task report(string what);
      n_fail++;
      if (n_fail <= 40) $display("MISMATCH %s", what);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("result %0d: %s is %0d, predicted %0d", n_results, name, got, want));
      end
    endtask

    task check_result(res_item_t got);
      res_item_t want;
      n_results++;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d arrived with no item outstanding", n_results));
      end else begin
        want = awaited.pop_front();
        check_field("event_res", 8'(got.event_res), 8'(want.event_res));
        check_field("reported_channel", 8'(got.reported_channel), 8'(want.reported_channel));
        check_field("tune_valid", 8'(got.tune_valid), 8'(want.tune_valid));
        check_field("tune_channel", 8'(got.tune_channel), 8'(want.tune_channel));
        check_field("hopping_on", 8'(got.hopping_on), 8'(want.hopping_on));
        check_field("error_kind", 8'(got.error_kind), 8'(want.error_kind));
        check_field("mode", 8'(got.mode), 8'(want.mode));
      end
    endtask

    task flush_leftovers();
      while (awaited.size() != 0) begin
        void'(awaited.pop_front());
        report("an event item never produced its result");
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rpc_in_if  in_ch ();
  rpc_out_if out_ch ();

  pairing_scoreboard sb = new();

  in_item_t    seen_in;
  res_item_t   seen_out;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned n_settings = 1;

  radio_pairing_controller_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Monitor: the input side is noted before the output side is checked, so
  // the outcome does not hang on which always block wakes first. The same
  // block keeps the watchdog on handshakes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_in.action           = action_t'(in_ch.action);
        seen_in.dial_request     = in_ch.dial_request;
        seen_in.detected_channel = in_ch.detected_channel;
        seen_in.packet_qualifies = in_ch.packet_qualifies;
        sb.note_event(seen_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_out.event_res        = event_t'(out_ch.event_res);
        seen_out.reported_channel = out_ch.reported_channel;
        seen_out.tune_valid       = out_ch.tune_valid;
        seen_out.tune_channel     = out_ch.tune_channel;
        seen_out.hopping_on       = out_ch.hopping_on;
        seen_out.error_kind       = out_ch.error_kind;
        seen_out.mode             = mode_t'(out_ch.mode);
        sb.check_result(seen_out);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result receiver. It switches at random between four stall styles: always
  // ready, mostly ready, a fixed duty pattern, or a coin toss per cycle.
  initial begin
    int unsigned cyc;
    int unsigned style;
    cyc   = 0;
    style = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) style = $urandom_range(0, 3);
      case (style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ((cyc % 7) >= 3);
        default: out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Offers one event item and returns at the edge where it is taken. The
  // sender works in bursts; when a burst runs out, valid drops for a random
  // gap first. Some bursts are long, giving stretches with no gaps at all.
  task automatic send_event(action_t act, logic [7:0] chan, logic [4:0] det, logic q);
    int unsigned gap;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid            <= 1'b1;
    in_ch.action           <= act;
    in_ch.dial_request     <= chan;
    in_ch.detected_channel <= det;
    in_ch.packet_qualifies <= q;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // The fields that the action does not use are filled at random.
  task automatic send_act(action_t act);
    send_event(act, 8'($urandom), 5'($urandom), 1'($urandom));
  endtask

  task automatic noise_event();
    send_event(action_t'($urandom_range(0, 7)), 8'($urandom), 5'($urandom), 1'($urandom));
  endtask

  task automatic send_packet(logic q);
    send_event(ACT_PACKET, 8'($urandom), 5'($urandom), q);
  endtask

  // Lets every outstanding result come out with valid held low. The first
  // edge makes sure the last accepted item has been noted.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic set_phase(logic [COUNT_W-1:0] thr, logic [WINDOW_W-1:0] win);
    drain();
    write_cfg(CFG_THRESHOLD, CFG_W'(thr));
    write_cfg(CFG_WINDOW, CFG_W'(win));
    n_settings++;
  endtask

  // One pairing attempt: start, a little scan traffic, a sync word (mostly
  // on a mapped channel), a body of packets and ticks with the odd failure,
  // stray sync or random item, then a little more traffic and, mostly, a stop or set channel.
  task automatic pairing_run(int unsigned body_len);
    logic [4:0]  det;
    int unsigned roll;
    send_act(ACT_START);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 1) != 0) send_act(ACT_TICK);
      else send_packet(1'($urandom));
    end
    if ($urandom_range(0, 3) != 0) det = DIAL_TO_RADIO[$urandom_range(0, 15)];
    else det = 5'($urandom_range(0, 31));
    send_event(ACT_SYNC, 8'($urandom), det, 1'($urandom));
    repeat (body_len) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        send_packet($urandom_range(0, 9) != 0);
      end else if (roll < 90) begin
        send_act(ACT_TICK);
      end else if (roll < 94) begin
        send_act(($urandom_range(0, 1) != 0) ? ACT_RX_FAIL : ACT_CAL_FAIL);
      end else if (roll < 97) begin
        send_event(ACT_SYNC, 8'($urandom), 5'($urandom), 1'($urandom));
      end else begin
        noise_event();
      end
    end
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 2) == 0) send_packet(1'($urandom));
      else send_act(ACT_TICK);
    end
    case ($urandom_range(0, 3))
      0: send_act(ACT_STOP);
      1: send_event(ACT_SET_CHAN, 8'($urandom_range(0, 15)), 5'($urandom), 1'($urandom));
      2: send_event(ACT_SET_CHAN, 8'($urandom), 5'($urandom), 1'($urandom));
      default: ;
    endcase
  endtask

  // Random traffic up to a running total of event items: mostly whole
  // pairing attempts, sometimes a short run of arbitrary items instead.
  task automatic random_traffic(int unsigned upto);
    while (sb.n_events < upto) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(2, 6)) noise_event();
      end else begin
        pairing_run($urandom_range(3, 25));
      end
    end
  endtask

  // A long qualifying stretch for a threshold of 255: on a mapped channel it
  // ends in success, on an unmapped one the count sits at its ceiling.
  task automatic long_haul(logic [4:0] det, int unsigned n);
    send_act(ACT_START);
    send_event(ACT_SYNC, 8'($urandom), det, 1'($urandom));
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) send_act(ACT_TICK);
      else send_packet($urandom_range(0, 19) != 0);
    end
    send_act(ACT_STOP);
  endtask

  initial begin
    rst_n                  <= 1'b0;
    cfg_wr_en              <= 1'b0;
    cfg_index              <= CFG_THRESHOLD;
    cfg_wdata              <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.action           <= ACT_TICK;
    in_ch.dial_request     <= '0;
    in_ch.detected_channel <= '0;
    in_ch.packet_qualifies <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset settings (threshold five, long window).
    // In idle a tick, a packet and a sync word are all ignored, and a
    // failure stays latched through a tick.
    send_act(ACT_TICK);
    send_packet(1'b1);
    send_event(ACT_SYNC, 8'd0, 5'd3, 1'b0);
    send_act(ACT_RX_FAIL);
    send_act(ACT_TICK);
    // Out-of-range dial channels are rejected, the top one is accepted, and
    // the latched rx failure is reported on the next tick in active.
    send_event(ACT_SET_CHAN, 8'd255, 5'd31, 1'b1);
    send_event(ACT_SET_CHAN, 8'd16, 5'd0, 1'b0);
    send_event(ACT_SET_CHAN, 8'd15, 5'd0, 1'b0);
    send_act(ACT_TICK);
    // A later failure overwrites an earlier one; only the last is reported.
    send_act(ACT_CAL_FAIL);
    send_act(ACT_RX_FAIL);
    send_act(ACT_CAL_FAIL);
    send_act(ACT_TICK);
    send_act(ACT_TICK);
    send_packet(1'b0);
    send_act(ACT_STOP);
    send_event(ACT_SET_CHAN, 8'd0, 5'd0, 1'b0);
    // Pairing on the highest dial channel: a packet while scanning is
    // ignored, a non-qualifying one does not count, five qualifying do.
    send_act(ACT_START);
    send_packet(1'b1);
    send_event(ACT_SYNC, 8'd0, DIAL_TO_RADIO[15], 1'b0);
    send_packet(1'b0);
    repeat (5) send_packet(1'b1);

    // Threshold zero succeeds on any packet for a mapped candidate; a one-tick window expires fast.
    set_phase(8'd0, 18'd1);
    random_traffic(160);
    set_phase(8'd1, 18'd2);
    random_traffic(290);
    set_phase(8'($urandom_range(2, 6)), 18'($urandom_range(3, 30)));
    random_traffic(440);
    // Highest threshold with the widest window: one success at the ceiling
    // and one unmapped candidate whose count saturates.
    set_phase(8'd255, 18'd262143);
    long_haul(DIAL_TO_RADIO[$urandom_range(0, 15)], 300);
    long_haul(5'd1, 300);
    set_phase(8'($urandom_range(0, 10)), 18'($urandom_range(1, 50)));
    random_traffic(1100);

    drain();
    repeat (4) @(posedge clk);
    sb.flush_leftovers();
    $display("Covered %0d event items and %0d results over %0d register settings.",
             sb.n_events, sb.n_results, n_settings);
    $display("Pairings %0d, window expiries %0d, errors reported %0d, channels rejected %0d.",
             sb.n_paired, sb.n_expired, sb.n_errors, sb.n_rejected);
    if (sb.n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
